/* hw/rtl/msc_pkg.sv */
// Shared constants, codes and types of the mean shift clustering block.
`timescale 1ns / 1ps
`default_nettype none
package msc_pkg;

  localparam int unsigned MAX_POINTS_DEF   = 64;
  localparam int unsigned MAX_CLUSTERS_DEF = 64;
  localparam int unsigned COORD_WIDTH_DEF  = 16;

  localparam int unsigned CFG_W     = 15;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned ITER_W    = 8;
  localparam int unsigned OUT_IDX_W = 6;
  localparam int unsigned OUT_CNT_W = 7;
  localparam int unsigned SQ_W      = 2 * CFG_W;

  localparam logic [CFG_W-1:0]  RESET_RADIUS    = CFG_W'(256);
  localparam logic [CFG_W-1:0]  RESET_THRESHOLD = CFG_W'(26);
  localparam logic [ITER_W-1:0] RESET_MAX_ITER  = ITER_W'(100);
  localparam logic [CFG_W-1:0]  RESET_MIN_DIST  = CFG_W'(26);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_RADIUS    = 2'd0,
    CFG_THRESHOLD = 2'd1,
    CFG_MAX_ITER  = 2'd2,
    CFG_MIN_DIST  = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_LOAD,
    ST_INIT,
    ST_CAP,
    ST_SCAN,
    ST_DIV,
    ST_SHIFT,
    ST_SWAIT,
    ST_MATCH,
    ST_PLACE,
    ST_EMIT
  } state_e;

  typedef struct packed {
    logic busy;
    logic vld;
  } unit_sts_t;

endpackage
`default_nettype wire

/* hw/rtl/mean_shift_point_clustering.sv */
// Points are loaded one per cycle; clustering starts after the request marked last.
// Per point: it is fetched as the start centre, then each iteration scans the point store,
// divides the three coordinate sums of the window by its count and shifts the centre; then the
// cluster table is scanned and the result is placed and emitted, waiting on out_ready_i.
// No input is taken during clustering. Reset clears counts and control registers; the point and
// cluster memories are not cleared, as only written entries are ever read.
`timescale 1ns / 1ps
`default_nettype none
module mean_shift_point_clustering #(
  parameter int unsigned MAX_POINTS   = msc_pkg::MAX_POINTS_DEF,
  parameter int unsigned MAX_CLUSTERS = msc_pkg::MAX_CLUSTERS_DEF,
  parameter int unsigned COORD_WIDTH  = msc_pkg::COORD_WIDTH_DEF
) (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_valid_i,
  output logic                                   cfg_ready_o,
  input  wire logic [msc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  wire logic [msc_pkg::CFG_W-1:0]         cfg_data_i,
  input  wire logic                              in_valid_i,
  output logic                                   in_ready_o,
  input  wire logic signed [COORD_WIDTH-1:0]     x_i,
  input  wire logic signed [COORD_WIDTH-1:0]     y_i,
  input  wire logic signed [COORD_WIDTH-1:0]     z_i,
  input  wire logic                              last_i,
  output logic                                   out_valid_o,
  input  wire logic                              out_ready_i,
  output logic [msc_pkg::OUT_IDX_W-1:0]          point_index_o,
  output logic [msc_pkg::OUT_IDX_W-1:0]          cluster_id_o,
  output logic [msc_pkg::OUT_CNT_W-1:0]          cluster_count_o,
  output logic                                   end_of_run_o
);

  localparam int unsigned CW   = COORD_WIDTH;
  localparam int unsigned PW   = 3 * CW;
  localparam int unsigned PCW  = $clog2(MAX_POINTS + 1);
  localparam int unsigned PAW  = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int unsigned CCW  = $clog2(MAX_CLUSTERS + 1);
  localparam int unsigned CAW  = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
  localparam int unsigned SW   = CW + PCW;
  localparam int unsigned DW   = 2 * CW + 4;
  localparam int unsigned SQW  = msc_pkg::SQ_W;
  localparam int unsigned CMPW = (DW > SQW) ? DW : SQW;
  localparam int unsigned IW   = msc_pkg::ITER_W;

  msc_pkg::state_e state_q, state_d;

  logic [msc_pkg::CFG_W-1:0] radius_q, thresh_q, min_dist_q;
  logic [IW-1:0]             max_iter_q;
  logic [SQW-1:0]            r2_q, t2_q, m2_q;

  logic [PCW-1:0] point_count_q;
  logic [CCW-1:0] clusters_q;
  logic [PAW-1:0] start_q;
  logic [PCW-1:0] idx_q;
  logic [CCW-1:0] cidx_q;
  logic [CCW-1:0] res_cnt_q;
  logic           rd_vld_q;
  logic [IW-1:0]  iter_q;
  logic [1:0]     div_k_q;
  logic [PCW-1:0] n_q;
  logic           hit_q;
  logic [CAW-1:0] hit_id_q;

  logic [PW-1:0]          center_q, next_q;
  logic signed [SW-1:0]   sum_q [3];

  logic [msc_pkg::OUT_IDX_W-1:0] out_idx_q, out_id_q;
  logic [msc_pkg::OUT_CNT_W-1:0] out_cnt_q;
  logic                          out_end_q;

  // Control strobes from the output decoder.
  logic           in_fire, out_fire, cfg_fire;
  logic           scan_issue, match_issue, scan_done, match_done;
  logic           p_re, p_we, c_re, c_we;
  logic [PAW-1:0] p_raddr;
  logic [PW-1:0]  p_rdata, c_rdata;
  logic           d_vld;
  logic [PW-1:0]  d_a;
  logic           div_start;
  logic [SW-1:0]  div_dividend;
  logic [SW-1:0]  div_quot;
  logic [CAW-1:0] place_id;
  logic           last_pt;
  logic           more_iter;
  logic [CW-1:0]  mean_coord;

  msc_pkg::unit_sts_t d_sts, div_sts;
  logic [DW-1:0]      d_d2;
  logic [PW-1:0]      d_a_out;

  assign cfg_ready_o = 1'b1;
  assign cfg_fire    = cfg_valid_i & cfg_ready_o;
  assign in_fire     = in_valid_i & in_ready_o;
  assign out_fire    = out_valid_o & out_ready_i;

  assign scan_done  = (idx_q == point_count_q) && !rd_vld_q && !d_sts.busy;
  assign match_done = (cidx_q == clusters_q) && !rd_vld_q && !d_sts.busy;
  assign last_pt    = (PCW'(start_q) + PCW'(1)) == point_count_q;
  assign more_iter  = ((IW + 1)'(iter_q) + (IW + 1)'(1) < (IW + 1)'(max_iter_q))
                   && (CMPW'(d_d2) > CMPW'(t2_q));

  // Next-state logic.
  always_comb begin
    state_d = state_q;
    case (state_q)
      msc_pkg::ST_LOAD:  if (in_fire && last_i) state_d = msc_pkg::ST_INIT;
      msc_pkg::ST_INIT:  state_d = msc_pkg::ST_CAP;
      msc_pkg::ST_CAP:   state_d = msc_pkg::ST_SCAN;
      msc_pkg::ST_SCAN: begin
        if (scan_done) begin
          state_d = (n_q == '0) ? msc_pkg::ST_MATCH : msc_pkg::ST_DIV;
        end
      end
      msc_pkg::ST_DIV: begin
        if (div_sts.vld && div_k_q == 2'd2) state_d = msc_pkg::ST_SHIFT;
      end
      msc_pkg::ST_SHIFT: state_d = msc_pkg::ST_SWAIT;
      msc_pkg::ST_SWAIT: begin
        if (d_sts.vld) state_d = more_iter ? msc_pkg::ST_SCAN : msc_pkg::ST_MATCH;
      end
      msc_pkg::ST_MATCH: if (match_done) state_d = msc_pkg::ST_PLACE;
      msc_pkg::ST_PLACE: state_d = msc_pkg::ST_EMIT;
      msc_pkg::ST_EMIT: begin
        if (out_ready_i) state_d = last_pt ? msc_pkg::ST_LOAD : msc_pkg::ST_INIT;
      end
      default: state_d = msc_pkg::ST_LOAD;
    endcase
  end

  // Output and strobe decoding.
  always_comb begin
    in_ready_o   = (state_q == msc_pkg::ST_LOAD);
    out_valid_o  = (state_q == msc_pkg::ST_EMIT);
    scan_issue   = (state_q == msc_pkg::ST_SCAN) && (idx_q < point_count_q);
    match_issue  = (state_q == msc_pkg::ST_MATCH) && (cidx_q < clusters_q);
    p_we         = in_fire && (point_count_q < PCW'(MAX_POINTS));
    p_re         = (state_q == msc_pkg::ST_INIT) || scan_issue;
    p_raddr      = (state_q == msc_pkg::ST_INIT) ? start_q : idx_q[PAW-1:0];
    c_re         = match_issue;
    c_we         = (state_q == msc_pkg::ST_PLACE) && !hit_q
                && (clusters_q < CCW'(MAX_CLUSTERS));
    d_vld        = rd_vld_q || (state_q == msc_pkg::ST_SHIFT);
    if (state_q == msc_pkg::ST_SHIFT) begin
      d_a = next_q;
    end else if (state_q == msc_pkg::ST_MATCH) begin
      d_a = c_rdata;
    end else begin
      d_a = p_rdata;
    end
    div_start    = (state_q == msc_pkg::ST_DIV) && !div_sts.busy && !div_sts.vld;
    div_dividend = sum_q[div_k_q][SW-1] ? SW'(-sum_q[div_k_q]) : SW'(sum_q[div_k_q]);
    if (hit_q) begin
      place_id = hit_id_q;
    end else if (clusters_q >= CCW'(MAX_CLUSTERS)) begin
      place_id = CAW'(MAX_CLUSTERS - 1);
    end else begin
      place_id = clusters_q[CAW-1:0];
    end
  end

  // Truncation toward zero: divide the magnitude, then restore the sign.
  assign mean_coord = sum_q[div_k_q][SW-1] ? CW'(SW'(0) - div_quot) : div_quot[CW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= msc_pkg::ST_LOAD;
      radius_q      <= msc_pkg::RESET_RADIUS;
      thresh_q      <= msc_pkg::RESET_THRESHOLD;
      max_iter_q    <= msc_pkg::RESET_MAX_ITER;
      min_dist_q    <= msc_pkg::RESET_MIN_DIST;
      point_count_q <= '0;
      clusters_q    <= '0;
      start_q       <= '0;
      idx_q         <= '0;
      cidx_q        <= '0;
      res_cnt_q     <= '0;
      rd_vld_q      <= 1'b0;
      iter_q        <= '0;
      div_k_q       <= '0;
      n_q           <= '0;
      hit_q         <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= scan_issue || match_issue;

      if (cfg_fire) begin
        case (msc_pkg::cfg_idx_e'(cfg_index_i))
          msc_pkg::CFG_RADIUS:    radius_q   <= cfg_data_i;
          msc_pkg::CFG_THRESHOLD: thresh_q   <= cfg_data_i;
          msc_pkg::CFG_MAX_ITER:  max_iter_q <= cfg_data_i[IW-1:0];
          msc_pkg::CFG_MIN_DIST:  min_dist_q <= cfg_data_i;
          default: ;
        endcase
      end

      if (p_we) point_count_q <= point_count_q + PCW'(1);
      if (in_fire && last_i) begin
        clusters_q <= '0;
        start_q    <= '0;
      end

      if (state_q == msc_pkg::ST_CAP) iter_q <= '0;
      if (state_q == msc_pkg::ST_SWAIT && d_sts.vld) iter_q <= iter_q + IW'(1);

      if (state_d == msc_pkg::ST_SCAN && state_q != msc_pkg::ST_SCAN) begin
        idx_q <= '0;
        n_q   <= '0;
      end else begin
        if (scan_issue) idx_q <= idx_q + PCW'(1);
        if (state_q == msc_pkg::ST_SCAN && d_sts.vld
            && CMPW'(d_d2) <= CMPW'(r2_q)) begin
          n_q <= n_q + PCW'(1);
        end
      end

      if (state_d == msc_pkg::ST_DIV && state_q != msc_pkg::ST_DIV) begin
        div_k_q <= '0;
      end else if (state_q == msc_pkg::ST_DIV && div_sts.vld) begin
        div_k_q <= div_k_q + 2'd1;
      end

      if (state_d == msc_pkg::ST_MATCH && state_q != msc_pkg::ST_MATCH) begin
        cidx_q    <= '0;
        res_cnt_q <= '0;
        hit_q     <= 1'b0;
      end else if (state_q == msc_pkg::ST_MATCH) begin
        if (match_issue) cidx_q <= cidx_q + CCW'(1);
        if (d_sts.vld) begin
          res_cnt_q <= res_cnt_q + CCW'(1);
          if (CMPW'(d_d2) < CMPW'(m2_q)) hit_q <= 1'b1;
        end
      end

      if (c_we) clusters_q <= clusters_q + CCW'(1);

      if (out_fire) begin
        if (last_pt) begin
          point_count_q <= '0;
        end else begin
          start_q <= start_q + PAW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    r2_q <= SQW'(radius_q) * SQW'(radius_q);
    t2_q <= SQW'(thresh_q) * SQW'(thresh_q);
    m2_q <= SQW'(min_dist_q) * SQW'(min_dist_q);

    if (state_q == msc_pkg::ST_CAP) center_q <= p_rdata;
    if (state_q == msc_pkg::ST_SWAIT && d_sts.vld) center_q <= next_q;

    if (state_d == msc_pkg::ST_SCAN && state_q != msc_pkg::ST_SCAN) begin
      for (int k = 0; k < 3; k++) sum_q[k] <= '0;
    end else if (state_q == msc_pkg::ST_SCAN && d_sts.vld
                 && CMPW'(d_d2) <= CMPW'(r2_q)) begin
      for (int k = 0; k < 3; k++) begin
        sum_q[k] <= sum_q[k] + SW'($signed(d_a_out[k*CW +: CW]));
      end
    end

    if (state_q == msc_pkg::ST_DIV && div_sts.vld) begin
      next_q[div_k_q*CW +: CW] <= mean_coord;
    end

    if (state_q == msc_pkg::ST_MATCH && d_sts.vld && !hit_q
        && CMPW'(d_d2) < CMPW'(m2_q)) begin
      hit_id_q <= res_cnt_q[CAW-1:0];
    end

    if (state_q == msc_pkg::ST_PLACE) begin
      out_idx_q <= msc_pkg::OUT_IDX_W'(start_q);
      out_id_q  <= msc_pkg::OUT_IDX_W'(place_id);
      out_cnt_q <= c_we ? msc_pkg::OUT_CNT_W'(clusters_q + CCW'(1))
                        : msc_pkg::OUT_CNT_W'(clusters_q);
      out_end_q <= last_pt;
    end
  end

  assign point_index_o   = out_idx_q;
  assign cluster_id_o    = out_id_q;
  assign cluster_count_o = out_cnt_q;
  assign end_of_run_o    = out_end_q;

  msc_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_POINTS)
  ) u_point_ram (
    .clk_i   (clk_i),
    .we_i    (p_we),
    .waddr_i (point_count_q[PAW-1:0]),
    .wdata_i ({z_i, y_i, x_i}),
    .re_i    (p_re),
    .raddr_i (p_raddr),
    .rdata_o (p_rdata)
  );

  msc_ram #(
    .WIDTH (PW),
    .DEPTH (MAX_CLUSTERS)
  ) u_cluster_ram (
    .clk_i   (clk_i),
    .we_i    (c_we),
    .waddr_i (clusters_q[CAW-1:0]),
    .wdata_i (center_q),
    .re_i    (c_re),
    .raddr_i (cidx_q[CAW-1:0]),
    .rdata_o (c_rdata)
  );

  msc_dist #(
    .CW (CW)
  ) u_dist (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .vld_i  (d_vld),
    .a_i    (d_a),
    .b_i    (center_q),
    .sts_o  (d_sts),
    .d2_o   (d_d2),
    .a_o    (d_a_out)
  );

  msc_div #(
    .NW (SW),
    .VW (PCW)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (n_q),
    .sts_o      (div_sts),
    .quot_o     (div_quot)
  );

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input taken while a result is pending");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    point_count_q <= PCW'(MAX_POINTS) && clusters_q <= CCW'(MAX_CLUSTERS))
    else $error("point or cluster count out of range");

  a_result_has_cluster: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (clusters_q != '0 && cluster_count_o != '0))
    else $error("result without any cluster");

  a_run_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_fire && end_of_run_o) |=> (in_ready_o && point_count_q == '0))
    else $error("run did not return to loading");

  a_div_only_with_points: assert property (@(posedge clk_i) disable iff (!rst_ni)
    div_start |-> n_q != '0)
    else $error("division by an empty window");

endmodule
`default_nettype wire

/* hw/rtl/msc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module msc_ram #(
  parameter int unsigned WIDTH = 48,
  parameter int unsigned DEPTH = 64,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic             re_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/msc_dist.sv */
// Two-stage squared Euclidean distance unit for 3-D points.
`timescale 1ns / 1ps
`default_nettype none
module msc_dist #(
  parameter int unsigned CW = msc_pkg::COORD_WIDTH_DEF,
  localparam int unsigned PW = 3 * CW,
  localparam int unsigned MW = CW + 1,
  localparam int unsigned QW = 2 * MW,
  localparam int unsigned DW = QW + 2
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              vld_i,
  input  wire logic [PW-1:0]     a_i,
  input  wire logic [PW-1:0]     b_i,
  output msc_pkg::unit_sts_t     sts_o,
  output logic      [DW-1:0]     d2_o,
  output logic      [PW-1:0]     a_o
);

  logic [QW-1:0] sq_d [3];
  logic [QW-1:0] sq_q [3];
  logic [PW-1:0] a1_q;
  logic          v1_q;
  logic          v2_q;

  always_comb begin
    logic signed [MW-1:0] diff;
    logic        [MW-1:0] mag;
    for (int k = 0; k < 3; k++) begin
      diff = MW'($signed(a_i[k*CW +: CW])) - MW'($signed(b_i[k*CW +: CW]));
      mag  = diff[MW-1] ? MW'(-diff) : MW'(diff);
      sq_d[k] = QW'(mag) * QW'(mag);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      v1_q <= vld_i;
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < 3; k++) begin
      sq_q[k] <= sq_d[k];
    end
    a1_q <= a_i;
    d2_o <= DW'(sq_q[0]) + DW'(sq_q[1]) + DW'(sq_q[2]);
    a_o  <= a1_q;
  end

  assign sts_o.busy = v1_q | v2_q;
  assign sts_o.vld  = v2_q;

endmodule
`default_nettype wire

/* hw/rtl/msc_div.sv */
// Serial restoring divider for unsigned magnitudes, one quotient bit per cycle.
`timescale 1ns / 1ps
`default_nettype none
module msc_div #(
  parameter int unsigned NW = 23,
  parameter int unsigned VW = 7,
  localparam int unsigned CNTW = $clog2(NW + 1)
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  input  wire logic [NW-1:0] dividend_i,
  input  wire logic [VW-1:0] divisor_i,
  output msc_pkg::unit_sts_t sts_o,
  output logic      [NW-1:0] quot_o
);

  logic [NW-1:0]   q_q;
  logic [VW-1:0]   r_q;
  logic [VW-1:0]   d_q;
  logic [CNTW-1:0] cnt_q;
  logic            busy_q;
  logic            done_q;
  logic [VW:0]     rs;
  logic            ge;

  assign rs = {r_q, q_q[NW-1]};
  assign ge = (rs >= {1'b0, d_q});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == CNTW'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNTW'(NW);
      end else if (busy_q) begin
        cnt_q <= cnt_q - CNTW'(1);
        if (cnt_q == CNTW'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      q_q <= dividend_i;
      r_q <= '0;
      d_q <= divisor_i;
    end else if (busy_q) begin
      r_q <= ge ? VW'(rs - {1'b0, d_q}) : rs[VW-1:0];
      q_q <= {q_q[NW-2:0], ge};
    end
  end

  assign quot_o     = q_q;
  assign sts_o.busy = busy_q;
  assign sts_o.vld  = done_q;

endmodule
`default_nettype wire
